### src/mbg_pkg.sv
package mbg_pkg;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_STEP  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [2:0] ACT_STARTED = 3'd0;
    localparam logic [2:0] ACT_CARVED  = 3'd1;
    localparam logic [2:0] ACT_BACK    = 3'd2;
    localparam logic [2:0] ACT_NOP     = 3'd3;
    localparam logic [2:0] ACT_READ    = 3'd4;

    localparam logic [1:0] DIR_N = 2'd0;
    localparam logic [1:0] DIR_E = 2'd1;
    localparam logic [1:0] DIR_S = 2'd2;
    localparam logic [1:0] DIR_W = 2'd3;

    localparam logic [4:0] OPEN_N = 5'h01;
    localparam logic [4:0] OPEN_E = 5'h02;
    localparam logic [4:0] OPEN_S = 5'h04;
    localparam logic [4:0] OPEN_W = 5'h08;
    localparam logic [4:0] SEEN   = 5'h10;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] rand_value;
        logic [15:0] rand_extra;
        logic [3:0]  cell_col;
        logic [2:0]  cell_row;
    } t_req;

    typedef struct packed {
        logic [2:0] action;
        logic [3:0] pos_col;
        logic [2:0] pos_row;
        logic [1:0] direction;
        logic [4:0] cell_bits;
        logic [7:0] visited_total;
        logic       complete;
    } t_rsp;

    function automatic logic [4:0] open_bit(input logic [1:0] d);
        logic [4:0] b;
        begin
            case (d)
                DIR_N:   b = OPEN_N;
                DIR_E:   b = OPEN_E;
                DIR_S:   b = OPEN_S;
                default: b = OPEN_W;
            endcase
            return b;
        end
    endfunction

    function automatic logic [1:0] opposite(input logic [1:0] d);
        return d ^ 2'd2;
    endfunction

endpackage

### src/mbg_if.sv
interface mbg_req_if;
    logic            valid;
    logic            ready;
    mbg_pkg::t_req   payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface mbg_rsp_if;
    logic            valid;
    logic            ready;
    mbg_pkg::t_rsp   payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### src/mbg_ram.sv
module mbg_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

### src/maze_backtracker_generator.sv
// Randomized depth-first maze carver. Every request returns exactly one
// response, and the next request is taken in the cycle after that response
// has been accepted. Cell walls and the path stack live in single-port
// memories with a registered read. A start request sweeps the cell memory
// clear, one address per cycle over all 2**(CW+RW) addresses. A reset does
// the same sweep before the first request is taken. After its sweep, a
// start marks its random first cell seen and pushes it on the stack. A read
// fetches the bits of one cell. A no-op step goes straight to the response.
// A step that carves does a stack read, the neighbor checks, the pick, two
// read-modify-writes of the cell memory and the stack write, all through
// the single ports. A backtrack pops the stack and reads the position and
// bits of the new top cell, or skips those reads when it empties the stack.
module maze_backtracker_generator #(
    parameter int GRID_COLS = 16,
    parameter int GRID_ROWS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mbg_req_if.sink   i_req,
    mbg_rsp_if.source o_rsp
);
    localparam int CELLS = GRID_COLS * GRID_ROWS;
    localparam int CW = $clog2(GRID_COLS);
    localparam int RW = $clog2(GRID_ROWS);
    localparam int AW = CW + RW;
    localparam int DW = $clog2(CELLS + 1);

    // Reciprocal constants for the remainders by the grid size and by three.
    localparam int CSH = 16 + $clog2(GRID_COLS);
    localparam int RSH = 16 + $clog2(GRID_ROWS);
    localparam int TSH = 18;
    localparam logic [16:0] CMUL =
        17'(((64'd1 << CSH) + 64'(GRID_COLS) - 64'd1) / 64'(GRID_COLS));
    localparam logic [16:0] RMUL =
        17'(((64'd1 << RSH) + 64'(GRID_ROWS) - 64'd1) / 64'(GRID_ROWS));
    localparam logic [16:0] TMUL = 17'(((64'd1 << TSH) + 64'd2) / 64'd3);

    typedef enum logic [12:0] {
        S_CLEAR  = 13'b0000000000001,
        S_IDLE   = 13'b0000000000010,
        S_RDWAIT = 13'b0000000000100,
        S_TOP    = 13'b0000000001000,
        S_NB     = 13'b0000000010000,
        S_PICK   = 13'b0000000100000,
        S_NEWRD  = 13'b0000001000000,
        S_NEWWR  = 13'b0000010000000,
        S_TOPRD  = 13'b0000100000000,
        S_TOPWR  = 13'b0001000000000,
        S_POPRD  = 13'b0010000000000,
        S_POPBIT = 13'b0100000000000,
        S_OUT    = 13'b1000000000000
    } t_state;

    t_state        r_state, n_state;
    logic [AW-1:0] r_clr;
    logic [DW-1:0] r_depth, r_visited;
    logic          r_active, r_start_pend;
    logic [AW-1:0] r_top, r_new;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [2:0]    r_nb;
    logic [3:0]    r_free;
    logic [15:0]   r_rand;
    logic [1:0]    r_dir;
    logic          r_nb_ok;
    logic          r_rd_ok;
    logic          r_ovalid;
    mbg_pkg::t_rsp r_rsp;
    mbg_pkg::t_rsp rsp_init;

    logic          c_we, s_we;
    logic [AW-1:0] c_addr, s_addr;
    logic [4:0]    c_wdata, c_rdata;
    logic [AW-1:0] s_wdata, s_rdata;

    mbg_ram #(.WIDTH(5), .DEPTH(1 << AW), .AW(AW)) u_cells (
        .i_clk(i_clk), .i_we(c_we), .i_addr(c_addr), .i_wdata(c_wdata), .o_rdata(c_rdata));
    mbg_ram #(.WIDTH(AW), .DEPTH(1 << AW), .AW(AW)) u_stack (
        .i_clk(i_clk), .i_we(s_we), .i_addr(s_addr), .i_wdata(s_wdata), .o_rdata(s_rdata));

    function automatic logic [AW-1:0] cidx(input logic [CW-1:0] c, input logic [RW-1:0] r);
        return {r, c};
    endfunction

    // Remainder of x by the constant d, with the quotient taken from a
    // multiplication by the rounded-up reciprocal.
    function automatic logic [15:0] rem_by(input logic [15:0] x, input logic [16:0] mul,
                                           input int sh, input logic [15:0] d);
        logic [32:0] prod;
        logic [15:0] quo;
        prod = {17'd0, x} * {16'd0, mul};
        quo = 16'(prod >> sh);
        return x - 16'(quo * d);
    endfunction

    // Neighbor address and existence of direction r_nb around the top cell.
    logic [CW-1:0] nb_col;
    logic [RW-1:0] nb_row;
    logic          nb_ok;
    always_comb begin
        nb_col = r_col;
        nb_row = r_row;
        nb_ok  = 1'b0;
        case (r_nb[1:0])
            mbg_pkg::DIR_N: begin
                nb_ok = r_row != '0; nb_row = r_row - 1'b1;
            end
            mbg_pkg::DIR_E: begin
                nb_ok = {1'b0, r_col} + 1'b1 < (CW+1)'(GRID_COLS); nb_col = r_col + 1'b1;
            end
            mbg_pkg::DIR_S: begin
                nb_ok = {1'b0, r_row} + 1'b1 < (RW+1)'(GRID_ROWS); nb_row = r_row + 1'b1;
            end
            default: begin
                nb_ok = r_col != '0; nb_col = r_col - 1'b1;
            end
        endcase
    end

    // Pick free direction number rand % count, in N,E,S,W order.
    logic [2:0] pk_cnt;
    logic [1:0] pk_sel;
    logic [1:0] pk_dir;
    logic [1:0] pk_seen;
    logic       pk_got;
    always_comb begin
        pk_cnt = 3'(r_free[0]) + 3'(r_free[1]) + 3'(r_free[2]) + 3'(r_free[3]);
        case (pk_cnt)
            3'd1: pk_sel = 2'd0;
            3'd2: pk_sel = {1'b0, r_rand[0]};
            3'd3: pk_sel = 2'(rem_by(r_rand, TMUL, TSH, 16'd3));
            default: pk_sel = r_rand[1:0];
        endcase
        pk_dir = mbg_pkg::DIR_N;
        pk_seen = 2'd0;
        pk_got = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (r_free[i] && !pk_got && pk_seen == pk_sel) begin
                pk_dir = 2'(i);
                pk_got = 1'b1;
            end
            if (r_free[i]) pk_seen = pk_seen + 2'd1;
        end
    end

    // Response fields known when a request is taken.
    always_comb begin
        rsp_init = '0;
        rsp_init.action = mbg_pkg::ACT_NOP;
        if (i_req.payload.kind == mbg_pkg::KIND_READ) begin
            rsp_init.action = mbg_pkg::ACT_READ;
            rsp_init.pos_col = i_req.payload.cell_col;
            rsp_init.pos_row = i_req.payload.cell_row;
        end
    end

    logic [CW-1:0] new_col;
    logic [RW-1:0] new_row;
    assign new_col = r_new[CW-1:0];
    assign new_row = r_new[AW-1:CW];

    always_comb begin
        n_state = r_state;
        c_we = 1'b0; c_addr = r_top; c_wdata = '0;
        s_we = 1'b0; s_addr = AW'(r_depth - 1'b1); s_wdata = r_new;
        i_req.ready = (r_state == S_IDLE) && !r_ovalid;
        case (r_state)
            S_CLEAR: begin
                c_we = 1'b1; c_addr = r_clr;
                if (r_clr == '1) n_state = r_start_pend ? S_NEWWR : S_IDLE;
            end
            S_IDLE: begin
                c_addr = cidx(i_req.payload.cell_col[CW-1:0], i_req.payload.cell_row[RW-1:0]);
                if (i_req.valid && !r_ovalid) begin
                    case (i_req.payload.kind)
                        mbg_pkg::KIND_START: n_state = S_CLEAR;
                        mbg_pkg::KIND_READ:  n_state = S_RDWAIT;
                        mbg_pkg::KIND_STEP:
                            n_state = (r_active && r_depth != '0 &&
                                       r_visited < DW'(CELLS)) ? S_TOP : S_OUT;
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_RDWAIT: n_state = S_OUT;
            S_TOP: n_state = S_NB;
            S_NB: begin
                c_addr = cidx(nb_col, nb_row);
                n_state = (r_nb == 3'd4) ? S_PICK : S_NB;
            end
            S_PICK: begin
                if (r_free == 4'd0) begin
                    s_addr = AW'(r_depth - 2'd2);
                    n_state = (r_depth == DW'(1)) ? S_OUT : S_POPRD;
                end else n_state = S_NEWRD;
            end
            S_NEWRD: begin
                c_addr = r_new;
                n_state = S_NEWWR;
            end
            S_NEWWR: begin
                c_addr = r_new; c_we = 1'b1;
                s_we = 1'b1; s_addr = r_depth[AW-1:0];
                c_wdata = r_start_pend ? mbg_pkg::SEEN
                        : (c_rdata | mbg_pkg::SEEN | mbg_pkg::open_bit(mbg_pkg::opposite(r_dir)));
                n_state = r_start_pend ? S_OUT : S_TOPRD;
            end
            S_TOPRD: begin
                c_addr = r_top; n_state = S_TOPWR;
            end
            S_TOPWR: begin
                c_addr = r_top; c_we = 1'b1;
                c_wdata = c_rdata | mbg_pkg::open_bit(r_dir);
                n_state = S_OUT;
            end
            S_POPRD: begin
                c_addr = s_rdata; n_state = S_POPBIT;
            end
            S_POPBIT: n_state = S_OUT;
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_depth <= '0;
            r_visited <= '0;
            r_active <= 1'b0;
            r_start_pend <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_rsp.valid && o_rsp.ready) r_ovalid <= 1'b0;
            case (r_state)
                S_CLEAR: r_clr <= r_clr + 1'b1;
                S_IDLE: begin
                    // The waiting response must stay put until it is taken.
                    if (i_req.valid && !r_ovalid) begin
                        r_clr <= '0;
                        r_rand <= i_req.payload.rand_value;
                        r_rsp <= rsp_init;
                        r_rd_ok <= {1'b0, i_req.payload.cell_col} < 5'(GRID_COLS) &&
                                   {1'b0, i_req.payload.cell_row} < 4'(GRID_ROWS);
                        r_nb <= '0;
                        r_free <= '0;
                        if (i_req.payload.kind == mbg_pkg::KIND_START) begin
                            r_start_pend <= 1'b1;
                            r_depth <= '0;
                            r_new <= cidx(
                                CW'(rem_by(i_req.payload.rand_value, CMUL, CSH,
                                           16'(GRID_COLS))),
                                RW'(rem_by(i_req.payload.rand_extra, RMUL, RSH,
                                           16'(GRID_ROWS))));
                        end
                    end
                end
                S_RDWAIT: r_rsp.cell_bits <= r_rd_ok ? c_rdata : '0;
                S_TOP: begin
                    r_top <= s_rdata;
                    r_col <= s_rdata[CW-1:0];
                    r_row <= s_rdata[AW-1:CW];
                end
                S_NB: begin
                    r_nb <= r_nb + 1'b1;
                    r_nb_ok <= nb_ok;
                    if (r_nb != 3'd0) r_free[r_nb[1:0] - 1'b1] <= r_nb_ok & ~c_rdata[4];
                end
                S_PICK: begin
                    r_dir <= pk_dir;
                    if (r_free != 4'd0) begin
                        case (pk_dir)
                            mbg_pkg::DIR_N: r_new <= cidx(r_col, r_row - 1'b1);
                            mbg_pkg::DIR_E: r_new <= cidx(r_col + 1'b1, r_row);
                            mbg_pkg::DIR_S: r_new <= cidx(r_col, r_row + 1'b1);
                            default:        r_new <= cidx(r_col - 1'b1, r_row);
                        endcase
                    end else begin
                        r_depth <= r_depth - 1'b1;
                        r_rsp.action <= mbg_pkg::ACT_BACK;
                    end
                end
                S_NEWWR: begin
                    r_depth <= r_depth + 1'b1;
                    r_rsp.pos_col <= 4'(new_col);
                    r_rsp.pos_row <= 3'(new_row);
                    r_rsp.cell_bits <= c_wdata;
                    if (r_start_pend) begin
                        r_start_pend <= 1'b0;
                        r_active <= 1'b1;
                        r_visited <= DW'(1);
                        r_rsp.action <= mbg_pkg::ACT_STARTED;
                    end else begin
                        r_visited <= r_visited + 1'b1;
                        r_rsp.action <= mbg_pkg::ACT_CARVED;
                        r_rsp.direction <= r_dir;
                    end
                end
                S_POPRD: begin
                    r_rsp.pos_col <= 4'(s_rdata[CW-1:0]);
                    r_rsp.pos_row <= 3'(s_rdata[AW-1:CW]);
                end
                S_POPBIT: r_rsp.cell_bits <= c_rdata;
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_rsp.visited_total <= 8'(r_visited);
                    r_rsp.complete <= r_visited == DW'(CELLS);
                end
                default: ;
            endcase
        end
    end

    assign o_rsp.valid = r_ovalid;
    assign o_rsp.payload = r_rsp;
endmodule
